/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/mrd_pkg.sv */
package mrd_pkg;

   localparam int MONTHS_PER_YEAR = 12;
   localparam int DAYS_PER_WEEK = 7;
   localparam int YEAR_MIN = 1;
   localparam int YEAR_MAX = 9999;

   // Bias that keeps the month sum non-negative, a whole number of years.
   localparam int YEAR_BIAS = 171;
   localparam int MONTH_BIAS = MONTHS_PER_YEAR * YEAR_BIAS;

   // Reciprocal constants for division by a constant.
   localparam int DIV100_MUL = 5243;
   localparam int DIV100_SHIFT = 19;
   localparam int DIV12_MUL = 5462;
   localparam int DIV12_SHIFT = 16;
   localparam int DIV7_MUL = 18725;
   localparam int DIV7_SHIFT = 17;
   localparam int DIV7_SMALL_MUL = 37;
   localparam int DIV7_SMALL_SHIFT = 8;

   typedef enum logic [1:0] {
      MODE_KEEP_DAY   = 2'd0,
      MODE_FROM_END   = 2'd1,
      MODE_WEEK_START = 2'd2,
      MODE_WEEK_END   = 2'd3
   } mrd_mode_type;

   typedef struct packed {
      logic first;
      logic second;
   } mrd_load_type;

   typedef struct packed {
      mrd_mode_type mode;
      logic [4:0]   day;
      logic [4:0]   dim_in;
      logic         in_ok;
      logic [13:0]  year_t;
      logic [3:0]   month_t;
      logic         year_t_ok;
      logic [13:0]  year_t_wd;
      logic [14:0]  sum_src;
   } mrd_front_type;

   typedef struct packed {
      mrd_mode_type mode;
      logic [4:0]   day;
      logic [4:0]   dim_in;
      logic         in_ok;
      logic [13:0]  year_t;
      logic [3:0]   month_t;
      logic         year_t_ok;
      logic [4:0]   dim_out;
      logic [2:0]   res_src;
      logic [14:0]  sum_t;
   } mrd_target_type;

   function automatic logic [4:0] days_in_month(logic leap, logic [3:0] month);
      logic [4:0] len;
      unique case (month)
         4'd2:                      len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

   function automatic logic [2:0] wd_offset(logic [3:0] month);
      logic [2:0] ofs;
      unique case (month)
         4'd2, 4'd6:   ofs = 3'd3;
         4'd3, 4'd11:  ofs = 3'd2;
         4'd4, 4'd7:   ofs = 3'd5;
         4'd8:         ofs = 3'd1;
         4'd9, 4'd12:  ofs = 3'd4;
         4'd10:        ofs = 3'd6;
         default:      ofs = 3'd0;
      endcase
      return ofs;
   endfunction

   function automatic logic [7:0] div100(logic [13:0] x);
      logic [26:0] prod;
      prod = 27'(x) * 27'(DIV100_MUL);
      return 8'(prod >> DIV100_SHIFT);
   endfunction

   function automatic logic is_leap(logic [13:0] year, logic [7:0] q100);
      logic century;
      century = (year == 14'(q100 * 100));
      return century ? (q100[1:0] == 2'b00) : (year[1:0] == 2'b00);
   endfunction

   function automatic logic [2:0] mod7(logic [14:0] x);
      logic [31:0] prod;
      logic [14:0] quo;
      prod = 32'(x) * 32'(DIV7_MUL);
      quo = 15'(prod >> DIV7_SHIFT);
      return 3'(x - 15'(quo * DAYS_PER_WEEK));
   endfunction

   function automatic logic [3:0] div7_small(logic [5:0] x);
      logic [11:0] prod;
      prod = 12'(x) * 12'(DIV7_SMALL_MUL);
      return 4'(prod >> DIV7_SMALL_SHIFT);
   endfunction

   // Weekday sum without the day term; the year is already moved back for
   // January and February.
   function automatic logic [14:0] weekday_sum(logic [13:0] year_wd, logic [7:0] q100_wd,
                                               logic [3:0] month);
      return 15'(year_wd) + 15'(year_wd >> 2) - 15'(q100_wd) + 15'(q100_wd >> 2)
             + 15'(wd_offset(month));
   endfunction

endpackage

/* rtl/monthly_recurrence_date.sv */
// Monthly recurrence date calculator.
// A request transaction carries a source date, a signed month offset and a
// placement mode; each request yields exactly one response transaction with
// the target year, month, raw day and a flag that marks a valid result.
// Both channels use valid and ready.
// The datapath is a six-stage pipeline: a request accepted at one clock edge
// moves through the front, target and place stages to the response channel.
// One request is accepted in every cycle unless the pipeline is full and
// stalled; the stages hold one transaction each, so up to six are in
// flight.
// When the receiver stalls, the response stays on the outputs unchanged and
// the stages behind it keep filling until every stage holds a transaction;
// only then does req_ready drop. Empty stages never hold traffic back.
// A synchronous reset empties the pipeline: no response is offered in the
// cycle after reset, and requests are taken again right away.
module monthly_recurrence_date import mrd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_mode,
   input  logic [13:0]        req_year_in,
   input  logic [3:0]         req_month_in,
   input  logic [4:0]         req_day_in,
   input  logic signed [11:0] req_month_offset,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [13:0]        rsp_year_out,
   output logic [3:0]         rsp_month_out,
   output logic signed [6:0]  rsp_day_out,
   output logic               rsp_valid_res
);

   logic [5:0] stage_valid_ff, stage_valid_in;
   logic [5:0] advance;

   mrd_load_type   front_load, target_load, place_load;
   mrd_front_type  front;
   mrd_target_type target;

   always_comb begin
      advance[5] = !stage_valid_ff[5] || rsp_ready;
      advance[4] = !stage_valid_ff[4] || advance[5];
      advance[3] = !stage_valid_ff[3] || advance[4];
      advance[2] = !stage_valid_ff[2] || advance[3];
      advance[1] = !stage_valid_ff[1] || advance[2];
      advance[0] = !stage_valid_ff[0] || advance[1];

      stage_valid_in[0] = advance[0] ? req_valid : stage_valid_ff[0];
      stage_valid_in[1] = advance[1] ? stage_valid_ff[0] : stage_valid_ff[1];
      stage_valid_in[2] = advance[2] ? stage_valid_ff[1] : stage_valid_ff[2];
      stage_valid_in[3] = advance[3] ? stage_valid_ff[2] : stage_valid_ff[3];
      stage_valid_in[4] = advance[4] ? stage_valid_ff[3] : stage_valid_ff[4];
      stage_valid_in[5] = advance[5] ? stage_valid_ff[4] : stage_valid_ff[5];

      front_load.first = advance[0];
      front_load.second = advance[1];
      target_load.first = advance[2];
      target_load.second = advance[3];
      place_load.first = advance[4];
      place_load.second = advance[5];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   assign req_ready = advance[0];
   assign rsp_valid = stage_valid_ff[5];

   mrd_front u_front (
      .clock        (clock),
      .load         (front_load),
      .mode         (req_mode),
      .year_in      (req_year_in),
      .month_in     (req_month_in),
      .day_in       (req_day_in),
      .month_offset (req_month_offset),
      .front        (front)
   );

   mrd_target u_target (
      .clock  (clock),
      .load   (target_load),
      .front  (front),
      .target (target)
   );

   mrd_place u_place (
      .clock     (clock),
      .load      (place_load),
      .target    (target),
      .year_out  (rsp_year_out),
      .month_out (rsp_month_out),
      .day_out   (rsp_day_out),
      .valid_res (rsp_valid_res)
   );

endmodule

/* rtl/mrd_front.sv */
module mrd_front import mrd_pkg::*; (
   input  logic                clock,
   input  mrd_load_type        load,
   input  logic [1:0]          mode,
   input  logic [13:0]         year_in,
   input  logic [3:0]          month_in,
   input  logic [4:0]          day_in,
   input  logic signed [11:0]  month_offset,
   output mrd_front_type       front
);

   typedef struct packed {
      mrd_mode_type mode;
      logic [13:0]  year;
      logic [3:0]   month;
      logic [4:0]   day;
      logic [13:0]  year_wd;
      logic [7:0]   q100;
      logic [7:0]   q100_wd;
      logic [12:0]  month_sum;
      logic [8:0]   month_quo;
   } front_s1_type;

   front_s1_type  s1_ff, s1_in;
   mrd_front_type s2_ff, s2_in;

   logic [12:0] month_sum_wide;
   logic [25:0] month_prod;
   logic [15:0] year_t_wide;
   logic [3:0]  month_rem;

   always_comb begin
      month_sum_wide = 13'(month_in) + 13'(month_offset) + 13'(MONTH_BIAS - 1);
      month_prod = 26'(month_sum_wide) * 26'(DIV12_MUL);

      s1_in.mode = mrd_mode_type'(mode);
      s1_in.year = year_in;
      s1_in.month = month_in;
      s1_in.day = day_in;
      s1_in.year_wd = year_in - 14'(month_in < 4'd3);
      s1_in.q100 = div100(year_in);
      s1_in.q100_wd = div100(s1_in.year_wd);
      s1_in.month_sum = month_sum_wide;
      s1_in.month_quo = 9'(month_prod >> DIV12_SHIFT);
   end

   always_comb begin
      month_rem = 4'(s1_ff.month_sum - 13'(s1_ff.month_quo * MONTHS_PER_YEAR));
      year_t_wide = 16'(s1_ff.year) + 16'(s1_ff.month_quo) - 16'(YEAR_BIAS);

      s2_in.mode = s1_ff.mode;
      s2_in.day = s1_ff.day;
      s2_in.dim_in = days_in_month(is_leap(s1_ff.year, s1_ff.q100), s1_ff.month);
      s2_in.in_ok = (s1_ff.year >= 14'(YEAR_MIN)) && (s1_ff.year <= 14'(YEAR_MAX))
                    && (s1_ff.month >= 4'd1) && (s1_ff.month <= 4'(MONTHS_PER_YEAR))
                    && (s1_ff.day >= 5'd1) && (s1_ff.day <= s2_in.dim_in);
      s2_in.month_t = month_rem + 4'd1;
      s2_in.year_t = year_t_wide[13:0];
      s2_in.year_t_ok = ($signed(year_t_wide) >= 16'sd1)
                        && ($signed(year_t_wide) <= $signed(16'(YEAR_MAX)));
      s2_in.year_t_wd = year_t_wide[13:0] - 14'(s2_in.month_t < 4'd3);
      s2_in.sum_src = weekday_sum(s1_ff.year_wd, s1_ff.q100_wd, s1_ff.month)
                      + 15'(s1_ff.day);
   end

   always_ff @(posedge clock) begin
      if (load.first) begin
         s1_ff <= s1_in;
      end
      if (load.second) begin
         s2_ff <= s2_in;
      end
   end

   assign front = s2_ff;

endmodule

/* rtl/mrd_target.sv */
module mrd_target import mrd_pkg::*; (
   input  logic           clock,
   input  mrd_load_type   load,
   input  mrd_front_type  front,
   output mrd_target_type target
);

   typedef struct packed {
      mrd_mode_type mode;
      logic [4:0]   day;
      logic [4:0]   dim_in;
      logic         in_ok;
      logic [13:0]  year_t;
      logic [3:0]   month_t;
      logic         year_t_ok;
      logic [13:0]  year_t_wd;
      logic [7:0]   q100_t;
      logic [7:0]   q100_t_wd;
      logic [2:0]   res_src;
   } target_s3_type;

   target_s3_type  s3_ff, s3_in;
   mrd_target_type s4_ff, s4_in;

   always_comb begin
      s3_in.mode = front.mode;
      s3_in.day = front.day;
      s3_in.dim_in = front.dim_in;
      s3_in.in_ok = front.in_ok;
      s3_in.year_t = front.year_t;
      s3_in.month_t = front.month_t;
      s3_in.year_t_ok = front.year_t_ok;
      s3_in.year_t_wd = front.year_t_wd;
      s3_in.q100_t = div100(front.year_t);
      s3_in.q100_t_wd = div100(front.year_t_wd);
      s3_in.res_src = mod7(front.sum_src);
   end

   always_comb begin
      s4_in.mode = s3_ff.mode;
      s4_in.day = s3_ff.day;
      s4_in.dim_in = s3_ff.dim_in;
      s4_in.in_ok = s3_ff.in_ok;
      s4_in.year_t = s3_ff.year_t;
      s4_in.month_t = s3_ff.month_t;
      s4_in.year_t_ok = s3_ff.year_t_ok;
      s4_in.dim_out = days_in_month(is_leap(s3_ff.year_t, s3_ff.q100_t), s3_ff.month_t);
      s4_in.res_src = s3_ff.res_src;
      s4_in.sum_t = weekday_sum(s3_ff.year_t_wd, s3_ff.q100_t_wd, s3_ff.month_t);
   end

   always_ff @(posedge clock) begin
      if (load.first) begin
         s3_ff <= s3_in;
      end
      if (load.second) begin
         s4_ff <= s4_in;
      end
   end

   assign target = s4_ff;

endmodule

/* rtl/mrd_place.sv */
module mrd_place import mrd_pkg::*; (
   input  logic               clock,
   input  mrd_load_type       load,
   input  mrd_target_type     target,
   output logic [13:0]        year_out,
   output logic [3:0]         month_out,
   output logic signed [6:0]  day_out,
   output logic               valid_res
);

   typedef struct packed {
      mrd_mode_type mode;
      logic [4:0]   day;
      logic [4:0]   dim_in;
      logic         in_ok;
      logic [13:0]  year_t;
      logic [3:0]   month_t;
      logic         year_t_ok;
      logic [4:0]   dim_out;
      logic [2:0]   res_src;
      logic [2:0]   res_base;
      logic [3:0]   week_start;
      logic [3:0]   week_end;
   } place_s5_type;

   place_s5_type s5_ff, s5_in;

   logic [13:0] year_ff, year_in;
   logic [3:0]  month_ff, month_in;
   logic [6:0]  day_ff, day_in;
   logic        valid_ff, valid_in;

   logic [2:0] res_first;
   logic [5:0] end_sum;
   logic [2:0] res_last;
   logic [2:0] shift_start;
   logic [2:0] back_end;
   logic [7:0] day_raw;
   logic       day_ok;

   always_comb begin
      s5_in.mode = target.mode;
      s5_in.day = target.day;
      s5_in.dim_in = target.dim_in;
      s5_in.in_ok = target.in_ok;
      s5_in.year_t = target.year_t;
      s5_in.month_t = target.month_t;
      s5_in.year_t_ok = target.year_t_ok;
      s5_in.dim_out = target.dim_out;
      s5_in.res_src = target.res_src;
      s5_in.res_base = mod7(target.sum_t);
      s5_in.week_start = div7_small(6'(target.day) - 6'd1);
      s5_in.week_end = div7_small(6'(target.dim_in) - 6'(target.day));
   end

   always_comb begin
      res_first = (s5_ff.res_base == 3'(DAYS_PER_WEEK - 1)) ? 3'd0 : s5_ff.res_base + 3'd1;
      end_sum = 6'(s5_ff.res_base) + 6'(s5_ff.dim_out);
      res_last = 3'(end_sum - 6'(div7_small(end_sum) * DAYS_PER_WEEK));

      shift_start = (s5_ff.res_src >= res_first)
                    ? s5_ff.res_src - res_first
                    : 3'(4'(s5_ff.res_src) + 4'(DAYS_PER_WEEK) - 4'(res_first));
      back_end = (res_last >= s5_ff.res_src)
                 ? res_last - s5_ff.res_src
                 : 3'(4'(res_last) + 4'(DAYS_PER_WEEK) - 4'(s5_ff.res_src));

      unique case (s5_ff.mode)
         MODE_KEEP_DAY: begin
            day_raw = 8'(s5_ff.day);
         end
         MODE_FROM_END: begin
            day_raw = 8'(s5_ff.dim_out) - 8'(s5_ff.dim_in) + 8'(s5_ff.day);
         end
         MODE_WEEK_START: begin
            day_raw = 8'd1 + 8'(shift_start) + 8'(s5_ff.week_start * DAYS_PER_WEEK);
         end
         MODE_WEEK_END: begin
            day_raw = 8'(s5_ff.dim_out) - 8'(back_end)
                      - 8'(s5_ff.week_end * DAYS_PER_WEEK);
         end
      endcase

      day_ok = ($signed(day_raw) >= 8'sd1) && ($signed(day_raw) <= $signed(8'(s5_ff.dim_out)));

      priority if (!s5_ff.in_ok) begin
         year_in = '0;
         month_in = 4'd1;
         day_in = '0;
         valid_in = 1'b0;
      end else if (!s5_ff.year_t_ok) begin
         year_in = '0;
         month_in = s5_ff.month_t;
         day_in = '0;
         valid_in = 1'b0;
      end else begin
         year_in = s5_ff.year_t;
         month_in = s5_ff.month_t;
         day_in = day_raw[6:0];
         valid_in = day_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (load.first) begin
         s5_ff <= s5_in;
      end
      if (load.second) begin
         year_ff <= year_in;
         month_ff <= month_in;
         day_ff <= day_in;
         valid_ff <= valid_in;
      end
   end

   assign year_out = year_ff;
   assign month_out = month_ff;
   assign day_out = $signed(day_ff);
   assign valid_res = valid_ff;

endmodule

/* rtl/mrd_checker.sv */
`include "assert_macros.svh"

module mrd_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [1:0]         req_mode,
   input logic [13:0]        req_year_in,
   input logic [3:0]         req_month_in,
   input logic [4:0]         req_day_in,
   input logic signed [11:0] req_month_offset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [13:0]        rsp_year_out,
   input logic [3:0]         rsp_month_out,
   input logic signed [6:0]  rsp_day_out,
   input logic               rsp_valid_res
);

   logic accept;
   assign accept = req_valid && req_ready;

   // A stalled response stays valid and holds its year and day.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_year_out) && $stable(rsp_day_out), "stalled response changed")

   // With the output stage free, req_ready is always high.
   `ASSERT_IMPLY(a_ready_when_free, clock, reset, !rsp_valid || rsp_ready, req_ready, "request refused with a free output stage")

   // A response follows an accepted request when the receiver keeps taking.
   `ASSERT_NEXT(a_latency, clock, reset, accept ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready, rsp_valid, "response missing after pipeline latency")

   // Reset leaves no response behind.
   `ASSERT_IMPLY(a_reset_empty, clock, reset, $past(reset), !rsp_valid, "response offered right after reset")

   // A result marked valid has year, month and day within their calendar ranges.
   `ASSERT_IMPLY(a_valid_date, clock, reset, rsp_valid && rsp_valid_res, rsp_year_out != 14'd0 && rsp_year_out <= 14'd9999 && rsp_month_out != 4'd0 && rsp_month_out <= 4'd12 && rsp_day_out > 7'sd0 && rsp_day_out <= 7'sd31, "valid flag on an impossible date")

endmodule

bind monthly_recurrence_date mrd_checker u_mrd_checker (.*);
